FILE: hw/rtl/slt_pkg.sv
// Shared types and constants for the sorted list table.
`default_nettype none
package slt_pkg;
    localparam int DEPTH     = 256;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic [2:0] FN_INSERT  = 3'd0;
    localparam logic [2:0] FN_INS_UNQ = 3'd1;
    localparam logic [2:0] FN_FIND    = 3'd2;
    localparam logic [2:0] FN_REMOVE  = 3'd3;
    localparam logic [2:0] FN_POP     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic shift_step;
        logic write_ins;
        logic finish;
    } slt_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic do_shift;
        logic do_write;
    } slt_stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/slt_ctrl.sv
// Sequencer for the sorted list table: scan, shift, write, respond.
`default_nettype none
module slt_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire logic             out_busy,
    input  wire slt_pkg::slt_stat_t stat,
    output slt_pkg::slt_cmd_t     cmd,
    output logic                  idle
);
    import slt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        idle = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    if (stat.do_shift)      state_next = S_SHIFT;
                    else if (stat.do_write) state_next = S_WRITE;
                    else                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (stat.shift_done)
                    state_next = stat.do_write ? S_WRITE : S_DONE;
            end
            S_WRITE: begin
                cmd.write_ins = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/slt_data.sv
// Entry memory, scan pointer, shifter and result datapath.
`default_nettype none
module slt_data (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [2:0]                in_func,
    input  wire logic [31:0]               in_operand,
    input  wire slt_pkg::slt_cmd_t         cmd,
    output slt_pkg::slt_stat_t             stat,
    output logic [7:0]                     res_position,
    output logic [1:0]                     res_status,
    output logic [31:0]                    res_popped,
    output logic [8:0]                     res_fill
);
    import slt_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic [2:0]              func_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        ptr_reg;     // scan index, then shift index
    logic [CNT_W-1:0]        k_reg;
    logic                    prev_eq_reg; // entry at ptr-1 equals value
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    rd_ok_reg;   // rd_data holds mem[ptr]
    logic                    sh_ok_reg;   // rd_data holds the next shift source
    logic                    do_shift_reg, do_write_reg;
    logic [1:0]              st_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] pop_reg;

    logic [IDX_W-1:0] rd_addr;
    logic             stop;
    logic             ins_op, le_op;
    logic             ins_full, ins_dup, rm_found;

    assign ins_op   = (func_reg == FN_INSERT) || (func_reg == FN_INS_UNQ);
    assign le_op    = ins_op || (func_reg == FN_FIND);
    assign ins_full = (count_reg == CNT_W'(DEPTH));
    assign ins_dup  = (func_reg == FN_INS_UNQ) && (ptr_reg != 0) && prev_eq_reg;
    assign rm_found = (func_reg == FN_REMOVE) && (ptr_reg != count_reg)
                      && (rd_data_reg == val_reg);

    // insert/find/remove scan stops at first entry failing compare or at end
    always_comb begin
        priority if (func_reg == FN_POP)
            stop = rd_ok_reg || (count_reg == '0);
        else if (func_reg > FN_POP)
            stop = 1'b1;
        else
            stop = (ptr_reg == count_reg) || (rd_ok_reg &&
                   (le_op ? !(rd_data_reg <= val_reg) : !(rd_data_reg < val_reg)));
    end

    always_comb begin
        rd_addr = ptr_reg[IDX_W-1:0];
        if (cmd.scan_step && rd_ok_reg && !stop)
            rd_addr = IDX_W'(ptr_reg + 1'b1);
        if (cmd.shift_step) begin
            if (sh_ok_reg)
                rd_addr = ins_op ? IDX_W'(ptr_reg - 2'd2) : IDX_W'(ptr_reg + 2'd2);
            else
                rd_addr = ins_op ? IDX_W'(ptr_reg - 1'b1) : IDX_W'(ptr_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.shift_step && sh_ok_reg) mem[ptr_reg[IDX_W-1:0]] <= rd_data_reg;
        if (cmd.write_ins) mem[k_reg[IDX_W-1:0]] <= val_reg;
    end

    always_comb begin
        stat.scan_done  = cmd.scan_step && stop;
        stat.do_shift   = do_shift_reg;
        stat.do_write   = do_write_reg;
        stat.shift_done = sh_ok_reg && (ins_op ? (ptr_reg == k_reg + 1'b1)
                                               : (ptr_reg + 1'b1 >= count_reg));
        if (cmd.scan_step && stop) begin
            priority if (ins_op) begin
                stat.do_write = !ins_full && !ins_dup;
                stat.do_shift = !ins_full && !ins_dup && (ptr_reg != count_reg);
            end else begin
                stat.do_write = 1'b0;
                stat.do_shift = rm_found && (ptr_reg + 1'b1 != count_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.scan_step && stop) begin
            if (ins_op && !ins_full && !ins_dup)
                count_next = count_reg + 1'b1;
            if (rm_found)
                count_next = count_reg - 1'b1;
            if (func_reg == FN_POP && count_reg != 0)
                count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            func_reg    <= in_func;
            val_reg     <= in_operand;
            ptr_reg     <= '0;
            rd_ok_reg   <= 1'b0;
            sh_ok_reg   <= 1'b0;
            prev_eq_reg <= 1'b0;
            pos_reg     <= '0;
            pop_reg     <= '0;
            st_reg      <= ST_OK;
            do_shift_reg <= 1'b0;
            do_write_reg <= 1'b0;
            if (in_func == FN_POP) begin
                // fetch the last entry, then finish
                if (count_reg == 0) st_reg <= ST_EMPTY;
                else                ptr_reg <= count_reg - 1'b1;
            end
        end else if (cmd.scan_step) begin
            if (!stop) begin
                rd_ok_reg <= 1'b1;
                if (rd_ok_reg) begin
                    prev_eq_reg <= (rd_data_reg == val_reg);
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end else begin
                k_reg        <= ptr_reg;
                do_shift_reg <= stat.do_shift;
                do_write_reg <= stat.do_write;
                if (func_reg == FN_POP) begin
                    if (st_reg == ST_OK) begin
                        pos_reg <= ptr_reg;
                        pop_reg <= rd_data_reg;
                    end
                end else if (ins_op) begin
                    if (ins_full) begin
                        st_reg <= ST_FULL;
                    end else if (ins_dup) begin
                        st_reg <= ST_MISS;
                    end else begin
                        pos_reg <= ptr_reg;
                        ptr_reg <= count_reg;
                    end
                end else if (func_reg == FN_FIND) begin
                    if (ptr_reg != 0 && prev_eq_reg) pos_reg <= ptr_reg - 1'b1;
                    else st_reg <= ST_MISS;
                end else if (func_reg == FN_REMOVE) begin
                    if (rm_found) pos_reg <= ptr_reg;
                    else st_reg <= ST_MISS;
                end
            end
        end else if (cmd.shift_step) begin
            sh_ok_reg <= 1'b1;
            if (sh_ok_reg) ptr_reg <= ins_op ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
        end
    end

    assign res_position = pos_reg[7:0];
    assign res_status   = st_reg;
    assign res_popped   = pop_reg;
    assign res_fill     = 9'(count_reg);
endmodule
`default_nettype wire

FILE: hw/rtl/sorted_list_table_top.sv
// Top level of the sorted list table: stream ports, sequencer and datapath.
// A request runs scan, then shift when entries must move, then write for an insert; the
// result is then registered onto m_tdata. Pop and unused codes skip shift and write.
// One request in flight; s_tready returns with m_tvalid, and a stalled result holds the
// next result in the done state until m_tready.
// Reset (aresetn low, synchronous) empties the table; entry storage is not cleared.
`default_nettype none
module sorted_list_table_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // func[2:0], operand[34:3], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // position[7:0], status[9:8], popped[41:10], fill[50:42]
);
    import slt_pkg::*;

    slt_cmd_t    cmd;
    slt_stat_t   stat;
    logic        idle, in_fire;
    logic [7:0]  pos;
    logic [1:0]  st;
    logic [31:0] pop;
    logic [8:0]  fill;
    logic        mv_reg;
    logic [50:0] md_reg;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;

    slt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .out_busy(mv_reg && !m_tready), .stat(stat), .cmd(cmd), .idle(idle)
    );

    slt_data u_data (
        .aclk(aclk), .aresetn(aresetn),
        .in_func(s_tdata[2:0]), .in_operand(s_tdata[34:3]),
        .cmd(cmd), .stat(stat),
        .res_position(pos), .res_status(st), .res_popped(pop), .res_fill(fill)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.finish) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) md_reg <= {fill, pop, st, pos};
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {5'b0, md_reg};
endmodule
`default_nettype wire
